/* sv/clw_pkg.sv */
// ----------------------------------------------------------------------------
// clw_pkg
// Shared types, codes and constants of the character LCD 4-bit write sequencer.
// ----------------------------------------------------------------------------
package clw_pkg;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  byte_value;
    logic [7:0]  row_number;
    logic [7:0]  column_number;
    logic [15:0] number_value;
  } in_beat_t;

  typedef struct packed {
    logic       reg_select;
    logic       enable_pin;
    logic [3:0] data_nibble;
    logic [4:0] hold_ms;
    logic       last_of_run;
  } out_beat_t;

  // request codes
  localparam logic [2:0] FN_INIT   = 3'd0;
  localparam logic [2:0] FN_CMD    = 3'd1;
  localparam logic [2:0] FN_CHAR   = 3'd2;
  localparam logic [2:0] FN_GOTO   = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;
  localparam logic [2:0] FN_NUMBER = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_FUNCTION_SET  = 3'd0;
  localparam logic [2:0] CFG_DISPLAY_ON    = 3'd1;
  localparam logic [2:0] CFG_CLEAR         = 3'd2;
  localparam logic [2:0] CFG_ENTRY_MODE    = 3'd3;
  localparam logic [2:0] CFG_SET_ADDRESS   = 3'd4;
  localparam logic [2:0] CFG_FIRST_ROW     = 3'd5;
  localparam logic [2:0] CFG_SECOND_ROW    = 3'd6;

  localparam logic [7:0] RST_FUNCTION_SET = 8'h28;
  localparam logic [7:0] RST_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] RST_CLEAR        = 8'h01;
  localparam logic [7:0] RST_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] RST_SET_ADDRESS  = 8'h80;
  localparam logic [7:0] RST_FIRST_ROW    = 8'h00;
  localparam logic [7:0] RST_SECOND_ROW   = 8'h40;

  // hold times in ms
  localparam logic [4:0] HOLD_POWER     = 5'd20;
  localparam logic [4:0] HOLD_STROBE    = 5'd1;
  localparam logic [4:0] HOLD_WAKE_LONG = 5'd6;
  localparam logic [4:0] HOLD_WAKE      = 5'd2;
  localparam logic [4:0] HOLD_BYTE_END  = 5'd3;
  localparam logic [4:0] HOLD_CLEAR_END = 5'd5;

  localparam logic [3:0] NIB_WAKE   = 4'h3;
  localparam logic [3:0] NIB_4BIT   = 4'h2;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam int         NUM_BITS   = 16;
  localparam int         NUM_DIGITS = 5;

  typedef enum logic [1:0] {
    BK_POWER,
    BK_NIB,
    BK_BYTE
  } beat_kind_t;

  typedef struct packed {
    logic       load;
    logic       conv_step;
    logic       emit;
    beat_kind_t kind;
    logic [1:0] phase;
    logic [2:0] idx;
    logic       last;
  } clw_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic [2:0] lead;
  } clw_stat_t;

endpackage

/* sv/char_lcd_4bit_write_sequencer_top.sv */
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer_top
// Expands LCD requests into timed pin states for a 4-bit character display.
// ----------------------------------------------------------------------------
// One request is taken when the block is idle and produces its pin states one
// beat per cycle while the output is not stalled: 4 beats per byte, 25 for
// init. A number request first runs a binary to BCD conversion, then finds the
// leading digit and sends 1 to 5 digit bytes. The request is registered on
// acceptance before its first beat; the next request is taken as soon as the
// last beat sits in the output register.
module char_lcd_4bit_write_sequencer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  clw_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output clw_pkg::out_beat_t  out_data
);
  import clw_pkg::*;

  clw_cmd_t  cmd;
  clw_stat_t stat;

  clw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  clw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.func == FN_INIT || in_data.func == FN_CMD ||
     in_data.func == FN_CHAR || in_data.func == FN_GOTO || in_data.func == FN_CLEAR ||
     in_data.func == FN_NUMBER)) |=> in_stall)
    else $error("request accepted without going busy");

  a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.enable_pin) |-> !out_data.last_of_run)
    else $error("run ends with enable high");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_run) |-> in_stall)
    else $error("new request taken inside a run");

endmodule

/* sv/clw_ctrl.sv */
// ----------------------------------------------------------------------------
// clw_ctrl
// Sequencing state machine: walks the beats of one request and steps the
// decimal conversion.
// ----------------------------------------------------------------------------
module clw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_func,
  output logic               in_stall,
  input  clw_pkg::clw_stat_t stat,
  output clw_pkg::clw_cmd_t  cmd
);
  import clw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POWER,
    ST_NIB,
    ST_BYTE,
    ST_CONV,
    ST_LEAD
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] idx_r,   idx_nxt;
  logic [3:0] conv_r,  conv_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    conv_nxt  = conv_r;
    cmd       = '0;
    cmd.phase = phase_r;
    cmd.idx   = idx_r;
    cmd.kind  = BK_BYTE;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          phase_nxt = 2'd0;
          idx_nxt   = 3'd0;
          conv_nxt  = 4'd0;
          case (in_func)
            FN_INIT:   state_nxt = ST_POWER;
            FN_CMD:    state_nxt = ST_BYTE;
            FN_CHAR:   state_nxt = ST_BYTE;
            FN_GOTO:   state_nxt = ST_BYTE;
            FN_CLEAR:  state_nxt = ST_BYTE;
            FN_NUMBER: state_nxt = ST_CONV;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POWER: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = BK_POWER;
          state_nxt = ST_NIB;
        end
      end
      ST_NIB: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = BK_NIB;
          if (phase_r[0]) begin
            phase_nxt = 2'd0;
            if (idx_r == 3'd3) begin
              state_nxt = ST_BYTE;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end else begin
            phase_nxt = 2'd1;
          end
        end
      end
      ST_BYTE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = BK_BYTE;
          cmd.last  = (phase_r == 2'd3) && (idx_r == 3'd0);
          phase_nxt = phase_r + 2'd1;
          if (phase_r == 2'd3) begin
            if (idx_r == 3'd0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - 3'd1;
            end
          end
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        conv_nxt      = conv_r + 4'd1;
        if (conv_r == 4'd15) begin
          state_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        idx_nxt   = stat.lead;
        phase_nxt = 2'd0;
        state_nxt = ST_BYTE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 2'd0;
      idx_r   <= 3'd0;
      conv_r  <= 4'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      conv_r  <= conv_nxt;
    end
  end

endmodule

/* sv/clw_dp.sv */
// ----------------------------------------------------------------------------
// clw_dp
// Datapath: configuration registers, request register, binary to BCD shifter,
// byte and pin-state selection, output register.
// ----------------------------------------------------------------------------
module clw_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  clw_pkg::in_beat_t   in_data,
  input  clw_pkg::clw_cmd_t   cmd,
  output clw_pkg::clw_stat_t  stat,
  input  logic                out_stall,
  output logic                out_valid,
  output clw_pkg::out_beat_t  out_data
);
  import clw_pkg::*;

  logic [7:0] fset_r, don_r, clr_r, entry_r, setaddr_r, row1_r, row2_r;
  in_beat_t   req_r;
  logic [NUM_BITS-1:0]     bin_r, bin_nxt;
  logic [4*NUM_DIGITS-1:0] bcd_r, bcd_nxt, bcd_adj;
  logic [3:0] pin_nibble_r;
  logic       out_valid_r;
  out_beat_t  out_r;
  out_beat_t  beat;

  logic [7:0] goto_col, goto_base, goto_addr;
  logic [3:0] digit;
  logic [7:0] cur_byte;
  logic       clr_byte;
  logic       data_rs;

  // binary to bcd, one bit per step
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
    {bcd_nxt, bin_nxt} = {bcd_adj[4*NUM_DIGITS-2:0], bin_r, 1'b0};
  end

  always_comb begin
    if (bcd_r[19:16] != 4'd0) begin
      stat.lead = 3'd4;
    end else if (bcd_r[15:12] != 4'd0) begin
      stat.lead = 3'd3;
    end else if (bcd_r[11:8] != 4'd0) begin
      stat.lead = 3'd2;
    end else if (bcd_r[7:4] != 4'd0) begin
      stat.lead = 3'd1;
    end else begin
      stat.lead = 3'd0;
    end
    stat.out_free = !out_valid_r || !out_stall;
  end

  // byte selection
  always_comb begin
    goto_col  = req_r.column_number - 8'd1;
    goto_base = (req_r.row_number == 8'd1) ? row1_r : row2_r;
    goto_addr = goto_base + goto_col;
    case (cmd.idx)
      3'd0:    digit = bcd_r[3:0];
      3'd1:    digit = bcd_r[7:4];
      3'd2:    digit = bcd_r[11:8];
      3'd3:    digit = bcd_r[15:12];
      3'd4:    digit = bcd_r[19:16];
      default: digit = 4'd0;
    endcase
    clr_byte = 1'b0;
    data_rs  = 1'b0;
    case (req_r.func)
      FN_INIT: begin
        case (cmd.idx)
          3'd3:    cur_byte = fset_r;
          3'd2:    cur_byte = don_r;
          3'd1:    cur_byte = clr_r;
          default: cur_byte = entry_r;
        endcase
        clr_byte = (cmd.idx == 3'd1);
      end
      FN_CMD:    cur_byte = req_r.byte_value;
      FN_CHAR: begin
        cur_byte = req_r.byte_value;
        data_rs  = 1'b1;
      end
      FN_GOTO:   cur_byte = setaddr_r | goto_addr;
      FN_CLEAR: begin
        cur_byte = clr_r;
        clr_byte = 1'b1;
      end
      FN_NUMBER: begin
        cur_byte = ASCII_ZERO + {4'd0, digit};
        data_rs  = 1'b1;
      end
      default:   cur_byte = 8'd0;
    endcase
  end

  // pin state of the current beat
  always_comb begin
    beat             = '0;
    beat.last_of_run = cmd.last;
    case (cmd.kind)
      BK_POWER: begin
        beat.data_nibble = pin_nibble_r;
        beat.hold_ms     = HOLD_POWER;
      end
      BK_NIB: begin
        beat.enable_pin  = !cmd.phase[0];
        beat.data_nibble = (cmd.idx == 3'd3) ? NIB_4BIT : NIB_WAKE;
        if (!cmd.phase[0]) begin
          beat.hold_ms = HOLD_STROBE;
        end else if (cmd.idx == 3'd0) begin
          beat.hold_ms = HOLD_WAKE_LONG;
        end else begin
          beat.hold_ms = HOLD_WAKE;
        end
      end
      BK_BYTE: begin
        beat.reg_select  = data_rs;
        beat.enable_pin  = !cmd.phase[0];
        beat.data_nibble = cmd.phase[1] ? cur_byte[3:0] : cur_byte[7:4];
        if (cmd.phase == 2'd3) begin
          beat.hold_ms = clr_byte ? HOLD_CLEAR_END : HOLD_BYTE_END;
        end else begin
          beat.hold_ms = HOLD_STROBE;
        end
      end
      default: beat = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fset_r       <= RST_FUNCTION_SET;
      don_r        <= RST_DISPLAY_ON;
      clr_r        <= RST_CLEAR;
      entry_r      <= RST_ENTRY_MODE;
      setaddr_r    <= RST_SET_ADDRESS;
      row1_r       <= RST_FIRST_ROW;
      row2_r       <= RST_SECOND_ROW;
      pin_nibble_r <= 4'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FUNCTION_SET: fset_r    <= cfg_wdata;
          CFG_DISPLAY_ON:   don_r     <= cfg_wdata;
          CFG_CLEAR:        clr_r     <= cfg_wdata;
          CFG_ENTRY_MODE:   entry_r   <= cfg_wdata;
          CFG_SET_ADDRESS:  setaddr_r <= cfg_wdata;
          CFG_FIRST_ROW:    row1_r    <= cfg_wdata;
          CFG_SECOND_ROW:   row2_r    <= cfg_wdata;
          default:          ;
        endcase
      end
      if (cmd.emit) begin
        pin_nibble_r <= beat.data_nibble;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
      bin_r <= in_data.number_value;
      bcd_r <= '0;
    end else if (cmd.conv_step) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
    if (cmd.emit) begin
      out_r <= beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* verif/char_lcd_4bit_write_sequencer_top_tb.sv */
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer_top_tb
// Self-checking bench for the 4-bit character LCD write sequencer.
// ----------------------------------------------------------------------------
// Requests go in on the input channel while a local model expands each accepted
// request into the pin states it should produce, with the register settings in
// force. Every pin state leaving the block is compared field by field with the
// oldest pending one. The run covers directed corner requests, zero and all-ones
// register settings, random traffic under three idle patterns and a long output
// stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module char_lcd_4bit_write_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clw_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 300;

  // request codes the block does not use
  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  typedef enum {REGS_ZERO, REGS_ONES, REGS_RANDOM} reg_fill_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [2:0] cfg_index = CFG_FUNCTION_SET;
  logic [7:0] cfg_wdata = 8'h00;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  logic [7:0] lcd_regs [0:6];
  logic [3:0] pin_nibble_now = 4'h0;
  logic       pin_rs_now     = 1'b0;
  out_beat_t  expected_pins [$];
  out_beat_t  want_pin;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_off_go   = 1'b0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;
  int   pin_count     = 0;
  int   error_count   = 0;

  char_lcd_4bit_write_sequencer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic void emit_pin(logic rs, logic en, logic [3:0] nib, logic [4:0] hold);
    out_beat_t b;
    b.reg_select  = rs;
    b.enable_pin  = en;
    b.data_nibble = nib;
    b.hold_ms     = hold;
    b.last_of_run = 1'b0;
    expected_pins.push_back(b);
    pin_rs_now     = rs;
    pin_nibble_now = nib;
  endfunction

  function automatic void strobe_nibble(logic rs, logic [3:0] nib, logic [4:0] low_hold);
    emit_pin(rs, 1'b1, nib, HOLD_STROBE);
    emit_pin(rs, 1'b0, nib, low_hold);
  endfunction

  function automatic void byte_pins(logic rs, logic [7:0] value, logic [4:0] end_hold);
    strobe_nibble(rs, value[7:4], HOLD_STROBE);
    strobe_nibble(rs, value[3:0], end_hold);
  endfunction

  function automatic void expand_request(in_beat_t req);
    int         start_len;
    int         n;
    int         i;
    int         v;
    logic [7:0] addr;
    logic [3:0] digits [NUM_DIGITS];
    out_beat_t  tail;
    start_len = expected_pins.size();
    case (req.func)
      FN_INIT: begin
        emit_pin(1'b0, 1'b0, pin_nibble_now, HOLD_POWER);
        strobe_nibble(1'b0, NIB_WAKE, HOLD_WAKE_LONG);
        strobe_nibble(1'b0, NIB_WAKE, HOLD_WAKE);
        strobe_nibble(1'b0, NIB_WAKE, HOLD_WAKE);
        strobe_nibble(1'b0, NIB_4BIT, HOLD_WAKE);
        byte_pins(1'b0, lcd_regs[CFG_FUNCTION_SET], HOLD_BYTE_END);
        byte_pins(1'b0, lcd_regs[CFG_DISPLAY_ON], HOLD_BYTE_END);
        byte_pins(1'b0, lcd_regs[CFG_CLEAR], HOLD_CLEAR_END);
        byte_pins(1'b0, lcd_regs[CFG_ENTRY_MODE], HOLD_BYTE_END);
      end
      FN_CMD:   byte_pins(1'b0, req.byte_value, HOLD_BYTE_END);
      FN_CHAR:  byte_pins(1'b1, req.byte_value, HOLD_BYTE_END);
      FN_GOTO: begin
        addr = ((req.row_number == 8'd1) ? lcd_regs[CFG_FIRST_ROW] : lcd_regs[CFG_SECOND_ROW])
               + req.column_number - 8'd1;
        byte_pins(1'b0, lcd_regs[CFG_SET_ADDRESS] | addr, HOLD_BYTE_END);
      end
      FN_CLEAR: byte_pins(1'b0, lcd_regs[CFG_CLEAR], HOLD_CLEAR_END);
      FN_NUMBER: begin
        v = req.number_value;
        n = 0;
        do begin
          digits[n] = 4'(v % 10);
          v = v / 10;
          n++;
        end while (v > 0);
        for (i = n - 1; i >= 0; i--)
          byte_pins(1'b1, ASCII_ZERO + 8'(digits[i]), HOLD_BYTE_END);
      end
      default: ;
    endcase
    if (expected_pins.size() > start_len) begin
      tail = expected_pins.pop_back();
      tail.last_of_run = 1'b1;
      expected_pins.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_pins.size() == 0) begin
        report_error($sformatf("pin state %0d not expected: %h", pin_count, out_data));
      end else begin
        want_pin = expected_pins.pop_front();
        if (out_data.reg_select !== want_pin.reg_select)
          report_error($sformatf("pin state %0d reg_select %b, want %b",
                                 pin_count, out_data.reg_select, want_pin.reg_select));
        if (out_data.enable_pin !== want_pin.enable_pin)
          report_error($sformatf("pin state %0d enable_pin %b, want %b",
                                 pin_count, out_data.enable_pin, want_pin.enable_pin));
        if (out_data.data_nibble !== want_pin.data_nibble)
          report_error($sformatf("pin state %0d data_nibble %h, want %h",
                                 pin_count, out_data.data_nibble, want_pin.data_nibble));
        if (out_data.hold_ms !== want_pin.hold_ms)
          report_error($sformatf("pin state %0d hold_ms %0d, want %0d",
                                 pin_count, out_data.hold_ms, want_pin.hold_ms));
        if (out_data.last_of_run !== want_pin.last_of_run)
          report_error($sformatf("pin state %0d last_of_run %b, want %b",
                                 pin_count, out_data.last_of_run, want_pin.last_of_run));
      end
      pin_count++;
    end
  end

  // receiver side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_off_go && hold_left == 0) begin
      hold_left   = HOLD_OFF_CYCLES;
      hold_off_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_request(input in_beat_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    expand_request(req);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_lcd_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx <= CFG_SECOND_ROW) lcd_regs[idx] = value;
  endtask

  // also hits the unused index, which must be ignored
  task automatic program_regs(input reg_fill_t fill);
    logic [7:0] value;
    for (int i = 0; i <= 7; i++) begin
      case (fill)
        REGS_ZERO: value = 8'h00;
        REGS_ONES: value = 8'hFF;
        default:   value = 8'($urandom);
      endcase
      write_lcd_reg(3'(i), value);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_beat_t make_request(logic [2:0] func, logic [7:0] value,
                                            logic [7:0] row, logic [7:0] col,
                                            logic [15:0] number);
    in_beat_t r;
    r.func          = func;
    r.byte_value    = value;
    r.row_number    = row;
    r.column_number = col;
    r.number_value  = number;
    return r;
  endfunction

  function automatic in_beat_t random_request();
    in_beat_t r;
    int       pick;
    r.byte_value    = 8'($urandom);
    r.row_number    = ($urandom_range(1) == 0) ? 8'd1 : 8'($urandom);
    r.column_number = 8'($urandom);
    case ($urandom_range(4))
      0:       r.number_value = 16'($urandom_range(9));
      1:       r.number_value = 16'($urandom_range(99));
      2:       r.number_value = 16'($urandom_range(999));
      3:       r.number_value = 16'($urandom_range(9999));
      default: r.number_value = 16'($urandom);
    endcase
    pick = $urandom_range(99);
    if (pick < 8)       r.func = FN_INIT;
    else if (pick < 26) r.func = FN_CMD;
    else if (pick < 50) r.func = FN_CHAR;
    else if (pick < 66) r.func = FN_GOTO;
    else if (pick < 74) r.func = FN_CLEAR;
    else if (pick < 96) r.func = FN_NUMBER;
    else                r.func = ($urandom_range(1) == 0) ? FN_SPARE_LO : FN_SPARE_HI;
    return r;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed_requests();
    send_request(make_request(FN_INIT,   8'h00, 8'd0,   8'd0,   16'd0));
    send_request(make_request(FN_CMD,    8'h00, 8'd0,   8'd0,   16'd0));
    send_request(make_request(FN_CMD,    8'hFF, 8'd0,   8'd0,   16'd0));
    send_request(make_request(FN_CHAR,   8'hFF, 8'd0,   8'd0,   16'd0));
    send_request(make_request(FN_CHAR,   8'h00, 8'd0,   8'd0,   16'd0));
    send_request(make_request(FN_GOTO,   8'h00, 8'd1,   8'd1,   16'd0));
    // column zero wraps to 255
    send_request(make_request(FN_GOTO,   8'h00, 8'd1,   8'd0,   16'd0));
    send_request(make_request(FN_GOTO,   8'h00, 8'd0,   8'd255, 16'd0));
    send_request(make_request(FN_GOTO,   8'h00, 8'd255, 8'd128, 16'd0));
    send_request(make_request(FN_CLEAR,  8'h00, 8'd0,   8'd0,   16'd0));
    send_request(make_request(FN_NUMBER, 8'h00, 8'd0,   8'd0,   16'd0));
    send_request(make_request(FN_NUMBER, 8'h00, 8'd0,   8'd0,   16'd9));
    send_request(make_request(FN_NUMBER, 8'h00, 8'd0,   8'd0,   16'd10));
    send_request(make_request(FN_NUMBER, 8'hFF, 8'hFF,  8'hFF,  16'hFFFF));
    // unused codes produce nothing
    send_request(make_request(FN_SPARE_LO, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    send_request(make_request(FN_SPARE_HI, 8'h5A, 8'h01, 8'h00, 16'h1234));
    // power-on state repeats the last nibble driven
    send_request(make_request(FN_INIT,   8'h00, 8'd0,   8'd0,   16'd0));
    wait_idle();
  endtask

  task automatic test_register_settings();
    program_regs(REGS_ZERO);
    send_request(make_request(FN_INIT,  8'h00, 8'd0, 8'd0,   16'd0));
    send_request(make_request(FN_GOTO,  8'h00, 8'd1, 8'd0,   16'd0));
    send_request(make_request(FN_CLEAR, 8'h00, 8'd0, 8'd0,   16'd0));
    wait_idle();
    program_regs(REGS_ONES);
    send_request(make_request(FN_INIT,  8'h00, 8'd7, 8'd0,   16'd0));
    send_request(make_request(FN_GOTO,  8'h00, 8'd7, 8'd255, 16'd0));
    send_request(make_request(FN_CLEAR, 8'h00, 8'd0, 8'd0,   16'd0));
    wait_idle();
  endtask

  task automatic test_random_traffic(input int items, input int sender_pct,
                                     input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (items) send_request(random_request());
    wait_idle();
  endtask

  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_go   = 1'b1;
    repeat (12) send_request(random_request());
    wait_idle();
  endtask

  initial begin
    lcd_regs[CFG_FUNCTION_SET] = RST_FUNCTION_SET;
    lcd_regs[CFG_DISPLAY_ON]   = RST_DISPLAY_ON;
    lcd_regs[CFG_CLEAR]        = RST_CLEAR;
    lcd_regs[CFG_ENTRY_MODE]   = RST_ENTRY_MODE;
    lcd_regs[CFG_SET_ADDRESS]  = RST_SET_ADDRESS;
    lcd_regs[CFG_FIRST_ROW]    = RST_FIRST_ROW;
    lcd_regs[CFG_SECOND_ROW]   = RST_SECOND_ROW;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_requests();
    test_register_settings();
    program_regs(REGS_RANDOM);
    test_random_traffic(45, 16, 85);
    program_regs(REGS_RANDOM);
    test_random_traffic(45, 85, 16);
    program_regs(REGS_RANDOM);
    test_random_traffic(35, 0, 0);
    test_backpressure_fill();

    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
sv/clw_pkg.sv
sv/clw_ctrl.sv
sv/clw_dp.sv
sv/char_lcd_4bit_write_sequencer_top.sv
verif/char_lcd_4bit_write_sequencer_top_tb.sv
